// ----- rtl/mpbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types, widths, register codes and helpers of the byte pattern matcher.
// ----------------------------------------------------------------------------
package mpbm_pkg;

  localparam int unsigned CFG_INDEX_BITS = 4;
  localparam int unsigned CFG_DATA_BITS  = 64;
  localparam int unsigned LEN_BITS       = 4;
  localparam int unsigned SLOT_BITS      = 2;
  localparam int unsigned START_BITS     = 32;
  localparam int unsigned NUM_CFG_SLOTS  = 4;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned DEF_PATTERN_SLOTS     = 4;
  localparam int unsigned DEF_MAX_PATTERN_BYTES = 8;
  localparam int unsigned DEF_POSITION_BITS     = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_FIRST = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LAST  = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_FIRST  = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_LAST   = 4'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  pattern_slot;
    logic [START_BITS-1:0] match_start;
    logic                  last_in_run;
  } out_item_t;

  function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len,
                                                    input int unsigned max_bytes);
    logic [LEN_BITS-1:0] lim;
    lim = LEN_BITS'(max_bytes);
    if (len > lim) begin
      return lim;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/multi_pattern_byte_matcher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_unit
// Streams file bytes against up to four configured byte patterns and reports
// slot and start offset of each non-overlapping match.
//
//   channel  direction  handshake                 payload
//   in_      input      in_push / in_full         in_item  (in_item_t)
//   out_     output     out_empty / out_pop       out_item (out_item_t)
//   cfg_     input      cfg_we                    cfg_index, cfg_wdata
//
// One byte is accepted per cycle while in_full is low; all slots compare in
// parallel in the front. Results leave one per cycle from the back while out_pop
// takes them, one per hit slot, via the queue, work and output registers.
// A four-entry record queue lets the front run ahead; in_full rises when it fills.
// Reset is synchronous and clears position, next-start marks and registers.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_unit
  import mpbm_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS     = DEF_PATTERN_SLOTS,
  parameter int unsigned MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int unsigned POSITION_BITS     = DEF_POSITION_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  input  wire in_item_t                  in_item,
  output logic                           in_full,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output out_item_t                      out_item,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int unsigned REG_SLOTS =
    (PATTERN_SLOTS < NUM_CFG_SLOTS) ? PATTERN_SLOTS : NUM_CFG_SLOTS;
  localparam int unsigned REC_BITS = PATTERN_SLOTS + POSITION_BITS;

  logic [CFG_DATA_BITS-1:0] pattern_r [REG_SLOTS];
  logic [LEN_BITS-1:0]      length_r  [REG_SLOTS];
  logic [CFG_DATA_BITS-1:0] slot_pattern [PATTERN_SLOTS];
  logic [LEN_BITS-1:0]      slot_len     [PATTERN_SLOTS];
  logic [SLOT_BITS-1:0]     cfg_slot;

  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_empty;
  logic [PATTERN_SLOTS-1:0] f_mask;
  logic [POSITION_BITS-1:0] f_pos;
  logic [PATTERN_SLOTS-1:0] b_mask;
  logic [POSITION_BITS-1:0] b_pos;

  assign cfg_slot = cfg_index[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < REG_SLOTS; s++) begin
        pattern_r[s] <= '0;
        length_r[s]  <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [REG_PATTERN_FIRST:REG_PATTERN_LAST]: begin
          for (int s = 0; s < REG_SLOTS; s++) begin
            if (cfg_slot == SLOT_BITS'(s)) begin
              pattern_r[s] <= cfg_wdata;
            end
          end
        end
        [REG_LENGTH_FIRST:REG_LENGTH_LAST]: begin
          for (int s = 0; s < REG_SLOTS; s++) begin
            if (cfg_slot == SLOT_BITS'(s)) begin
              length_r[s] <= cfg_wdata[LEN_BITS-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < PATTERN_SLOTS; g++) begin : g_slot
    if (g < REG_SLOTS) begin : g_reg
      assign slot_pattern[g] = pattern_r[g];
      assign slot_len[g]     = length_r[g];
    end else begin : g_none
      assign slot_pattern[g] = '0;
      assign slot_len[g]     = '0;
    end
  end

  mpbm_front #(
    .PATTERN_SLOTS     (PATTERN_SLOTS),
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .POSITION_BITS     (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_item      (in_item),
    .in_full      (in_full),
    .slot_pattern (slot_pattern),
    .slot_len     (slot_len),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_mask       (f_mask),
    .q_pos        (f_pos)
  );

  mpbm_queue #(
    .WIDTH (REC_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_mask, f_pos}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({b_mask, b_pos}),
    .empty (q_empty)
  );

  mpbm_back #(
    .PATTERN_SLOTS     (PATTERN_SLOTS),
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .POSITION_BITS     (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .slot_len  (slot_len),
    .q_empty   (q_empty),
    .q_mask    (b_mask),
    .q_pos     (b_pos),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("record pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("record popped from an empty queue");

  a_record_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (f_mask != '0))
    else $error("record pushed without any slot hit");

  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

endmodule
`default_nettype wire

// ----- rtl/mpbm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_queue
// Small register queue carrying match records from the front to the back.
// ----------------------------------------------------------------------------
module mpbm_queue
  import mpbm_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mpbm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_front
// Accepts file bytes, keeps history, position and per-slot next start, and
// classifies each byte into a mask of slots whose pattern ends there.
// ----------------------------------------------------------------------------
module mpbm_front
  import mpbm_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS     = DEF_PATTERN_SLOTS,
  parameter int unsigned MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int unsigned POSITION_BITS     = DEF_POSITION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  input  wire in_item_t                 in_item,
  output logic                          in_full,
  input  wire logic [CFG_DATA_BITS-1:0] slot_pattern [PATTERN_SLOTS],
  input  wire logic [LEN_BITS-1:0]      slot_len     [PATTERN_SLOTS],
  input  wire logic                     q_full,
  output logic                          q_push,
  output logic [PATTERN_SLOTS-1:0]      q_mask,
  output logic [POSITION_BITS-1:0]      q_pos
);

  localparam int unsigned HIST_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
  localparam int unsigned WIN_BITS   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [7:0]               hist_r [HIST_DEPTH];
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [POSITION_BITS-1:0] nas_r [PATTERN_SLOTS];
  logic [7:0]               win [MAX_PATTERN_BYTES];
  logic [PATTERN_SLOTS-1:0] hit;
  logic                     accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && (hit != '0);
  assign q_mask  = hit;
  assign q_pos   = pos_r;

  always_comb begin
    win[0] = in_item.data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win[j] = hist_r[j-1];
    end
  end

  always_comb begin
    logic [LEN_BITS-1:0]      len_eff;
    logic [LEN_BITS-1:0]      back;
    logic [POSITION_BITS-1:0] lenm1;
    logic                     eq;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      len_eff = clamp_len(slot_len[s], MAX_PATTERN_BYTES);
      lenm1   = POSITION_BITS'(len_eff - 1'b1);
      eq      = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        back = len_eff - 1'b1 - LEN_BITS'(i);
        if ((LEN_BITS'(i) < len_eff) &&
            (slot_pattern[s][8*i +: 8] != win[back[WIN_BITS-1:0]])) begin
          eq = 1'b0;
        end
      end
      hit[s] = (pos_r != POS_MAX) && (len_eff != '0) && (pos_r >= lenm1) &&
               ((pos_r - lenm1) >= nas_r[s]) && eq;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (in_item.end_of_file) begin
      pos_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        nas_r[s] <= '0;
      end
    end else if (accept) begin
      pos_r <= pos_nxt;
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        if (in_item.end_of_file) begin
          nas_r[s] <= '0;
        end else if (hit[s]) begin
          nas_r[s] <= pos_r + 1'b1;
        end
      end
    end
  end

  // history is only read once enough bytes of the current file have arrived
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r[0] <= in_item.data_byte;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mpbm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_back
// Takes match records from the queue and emits one result per set slot,
// lowest slot first, through a registered output stage.
// ----------------------------------------------------------------------------
module mpbm_back
  import mpbm_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS     = DEF_PATTERN_SLOTS,
  parameter int unsigned MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int unsigned POSITION_BITS     = DEF_POSITION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [LEN_BITS-1:0]      slot_len [PATTERN_SLOTS],
  input  wire logic                     q_empty,
  input  wire logic [PATTERN_SLOTS-1:0] q_mask,
  input  wire logic [POSITION_BITS-1:0] q_pos,
  output logic                          q_pop,
  input  wire logic                     out_pop,
  output logic                          out_empty,
  output out_item_t                     out_item
);

  localparam int unsigned SEL_BITS  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int unsigned WIDE_BITS = (POSITION_BITS > START_BITS) ? POSITION_BITS : START_BITS;

  logic                     work_valid_r;
  logic [PATTERN_SLOTS-1:0] work_mask_r;
  logic [POSITION_BITS-1:0] work_pos_r;
  logic                     out_valid_r;
  out_item_t                out_item_r;
  out_item_t                out_item_nxt;
  logic [SEL_BITS-1:0]      sel;
  logic [PATTERN_SLOTS-1:0] rest;
  logic                     last;
  logic [LEN_BITS-1:0]      lenm1;
  logic [POSITION_BITS-1:0] start;
  logic [WIDE_BITS-1:0]     start_wide;
  logic                     out_load;
  logic                     work_done;

  always_comb begin
    sel = '0;
    for (int s = PATTERN_SLOTS - 1; s >= 0; s--) begin
      if (work_mask_r[s]) begin
        sel = SEL_BITS'(s);
      end
    end
  end

  assign rest       = work_mask_r & ~(PATTERN_SLOTS'(1) << sel);
  assign last       = (rest == '0);
  assign lenm1      = clamp_len(slot_len[sel], MAX_PATTERN_BYTES) - 1'b1;
  assign start      = work_pos_r - POSITION_BITS'(lenm1);
  assign start_wide = WIDE_BITS'(start);

  assign out_load  = work_valid_r && (!out_valid_r || out_pop);
  assign work_done = out_load && last;
  assign q_pop     = !q_empty && (!work_valid_r || work_done);

  always_comb begin
    out_item_nxt.pattern_slot = SLOT_BITS'(sel);
    out_item_nxt.match_start  = start_wide[START_BITS-1:0];
    out_item_nxt.last_in_run  = last;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        work_valid_r <= 1'b1;
      end else if (work_done) begin
        work_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_mask_r <= q_mask;
      work_pos_r  <= q_pos;
    end else if (out_load) begin
      work_mask_r <= rest;
    end
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- bench/multi_pattern_byte_matcher_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_pattern_byte_matcher_unit_tb
// Self-checking bench for the byte pattern matcher. A directed table covers
// reset state, byte extremes, end of file, clamped lengths, identical slots
// and short files; random phases then stream pattern-heavy byte files under
// changing register settings and handshake idling. Each result is checked
// against its table row or an in-bench matcher model in step with input.
// ---------------------------------------------------------------------------
module multi_pattern_byte_matcher_unit_tb;
  import mpbm_pkg::*;

  localparam int unsigned SLOTS           = DEF_PATTERN_SLOTS;
  localparam int unsigned MAX_BYTES       = DEF_MAX_PATTERN_BYTES;
  localparam int unsigned POS_BITS        = DEF_POSITION_BITS;
  localparam int unsigned POS_EXT         = POS_BITS + 1;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned REPORT_CAP      = 200;
  localparam int unsigned DIRECTED_ROWS   = 24;
  localparam int unsigned SET_B_FIRST     = 3;
  localparam int unsigned SET_C_FIRST     = 14;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       typed;
    logic       has_hit;
    out_item_t  hit;
  } step_row_t;

  typedef struct packed {
    logic [SLOTS-1:0][CFG_DATA_BITS-1:0] pattern;
    logic [SLOTS-1:0][LEN_BITS-1:0]      length;
  } pattern_set_t;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_push   = 1'b0;
  in_item_t                  in_item   = '0;
  logic                      in_full;
  logic                      out_empty;
  logic                      out_pop   = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  multi_pattern_byte_matcher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [CFG_DATA_BITS-1:0] slot_pattern [SLOTS];
  logic [LEN_BITS-1:0]      slot_length  [SLOTS];
  logic [7:0]               byte_hist    [MAX_BYTES-1];
  logic [POS_BITS-1:0]      byte_pos;
  logic [POS_BITS:0]        next_start   [SLOTS];
  out_item_t                pending_matches [$];

  step_row_t   directed_rows [DIRECTED_ROWS];
  int unsigned tx_idle_pct = 32;
  int unsigned rx_idle_pct = 78;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned slot_span(input int s);
    return (slot_length[s] > MAX_BYTES) ? MAX_BYTES : int'(slot_length[s]);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h5A;
      2:       return 8'hA5;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic step_row_t mk_row(input logic [7:0] data_byte, input logic eof,
                                       input logic typed, input logic has_hit,
                                       input int unsigned slot, input int unsigned start_pos);
    step_row_t row;
    row.data_byte        = data_byte;
    row.end_of_file      = eof;
    row.typed            = typed;
    row.has_hit          = has_hit;
    row.hit.pattern_slot = SLOT_BITS'(slot);
    row.hit.match_start  = START_BITS'(start_pos);
    row.hit.last_in_run  = has_hit;
    return row;
  endfunction

  function automatic pattern_set_t random_set();
    pattern_set_t set;
    for (int s = 0; s < SLOTS; s++) begin
      for (int b = 0; b < MAX_BYTES; b++) begin
        set.pattern[s][8*b +: 8] = pick_byte();
      end
      case ($urandom_range(0, 9))
        0:       set.length[s] = '0;
        1:       set.length[s] = LEN_BITS'(MAX_BYTES);
        2:       set.length[s] = LEN_BITS'($urandom_range(MAX_BYTES + 1, 15));
        default: set.length[s] = LEN_BITS'($urandom_range(1, 4));
      endcase
    end
    return set;
  endfunction

  task automatic clear_stream();
    for (int k = 0; k < MAX_BYTES - 1; k++) begin
      byte_hist[k] = '0;
    end
    byte_pos = '0;
    for (int s = 0; s < SLOTS; s++) begin
      next_start[s] = '0;
    end
  endtask

  // Match every slot against the current byte and history, then advance.
  task automatic predict_matches(input in_item_t it, input bit keep);
    logic [7:0]          window [MAX_BYTES];
    out_item_t           hits   [SLOTS];
    int unsigned         n_hits;
    int unsigned         len;
    logic [POS_BITS-1:0] start_pos;
    bit                  found;
    n_hits = 0;
    window[0] = it.data_byte;
    for (int k = 1; k < MAX_BYTES; k++) begin
      window[k] = byte_hist[k-1];
    end
    if (byte_pos != '1) begin
      for (int s = 0; s < SLOTS; s++) begin
        len = slot_span(s);
        if (len != 0 && byte_pos >= len - 1) begin
          start_pos = byte_pos - POS_BITS'(len - 1);
          found = ({1'b0, start_pos} >= next_start[s]);
          for (int i = 0; i < len; i++) begin
            if (slot_pattern[s][8*i +: 8] != window[len-1-i]) begin
              found = 1'b0;
            end
          end
          if (found) begin
            next_start[s] = {1'b0, start_pos} + POS_EXT'(len);
            hits[n_hits].pattern_slot = SLOT_BITS'(s);
            hits[n_hits].match_start  = START_BITS'(start_pos);
            hits[n_hits].last_in_run  = 1'b0;
            n_hits++;
          end
        end
      end
    end
    if (n_hits > 0) begin
      hits[n_hits-1].last_in_run = 1'b1;
    end
    if (keep) begin
      for (int j = 0; j < n_hits; j++) begin
        pending_matches = {pending_matches, hits[j]};
      end
    end
    if (it.end_of_file) begin
      clear_stream();
    end else begin
      for (int k = MAX_BYTES - 2; k > 0; k--) begin
        byte_hist[k] = byte_hist[k-1];
      end
      byte_hist[0] = it.data_byte;
      if (byte_pos != '1) begin
        byte_pos = byte_pos + 1'b1;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_patterns(input pattern_set_t set);
    logic [CFG_DATA_BITS-1:0] junk;
    for (int s = 0; s < SLOTS; s++) begin
      write_reg(REG_PATTERN_FIRST + CFG_INDEX_BITS'(s), set.pattern[s]);
      slot_pattern[s] = set.pattern[s];
    end
    for (int s = 0; s < SLOTS; s++) begin
      junk = {$urandom, $urandom};
      write_reg(REG_LENGTH_FIRST + CFG_INDEX_BITS'(s),
                {junk[CFG_DATA_BITS-1:LEN_BITS], set.length[s]});
      slot_length[s] = set.length[s];
    end
    // unmapped index: must leave every register untouched
    write_reg(REG_LENGTH_LAST + CFG_INDEX_BITS'($urandom_range(1, 8)), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input in_item_t it, input bit keep);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    predict_matches(it, keep);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly whole patterns of active slots, mixed with loose bytes and early ends.
  task automatic run_random(input int unsigned count);
    logic [7:0]  burst [$];
    in_item_t    it;
    int unsigned s;
    int unsigned len;
    for (int n = 0; n < count; n++) begin
      if (burst.size() == 0) begin
        s   = $urandom_range(0, SLOTS - 1);
        len = slot_span(s);
        if (len != 0 && $urandom_range(0, 99) < 40) begin
          for (int b = 0; b < len; b++) begin
            burst = {burst, slot_pattern[s][8*b +: 8]};
          end
        end else begin
          burst = {burst, pick_byte()};
        end
      end
      it.data_byte   = burst.pop_front();
      it.end_of_file = ($urandom_range(0, 31) == 0);
      send_item(it, 1'b1);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_matches.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t ns: unexpected transaction: expected none, got slot %0d start %0d last %0d",
                 $time, got.pattern_slot, got.match_start, got.last_in_run);
      end
    end else begin
      want = pending_matches.pop_front();
      if (got.pattern_slot !== want.pattern_slot || got.match_start !== want.match_start ||
          got.last_in_run !== want.last_in_run) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
          $display({"%0t ns: mismatch: expected slot %0d start %0d last %0d, ",
                    "got slot %0d start %0d last %0d"},
                   $time, want.pattern_slot, want.match_start, want.last_in_run,
                   got.pattern_slot, got.match_start, got.last_in_run);
        end
      end
    end
  endtask

  initial begin : drain_side
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        check_result(out_item);
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    step_row_t    row;
    pattern_set_t set_b;
    pattern_set_t set_c;
    in_item_t     it;

    directed_rows[0] = mk_row(8'h00, 1'b0, 1'b1, 1'b0, 0, 0);
    directed_rows[1] = mk_row(8'hFF, 1'b0, 1'b1, 1'b0, 0, 0);
    directed_rows[2] = mk_row(8'h00, 1'b1, 1'b1, 1'b0, 0, 0);
    directed_rows[3] = mk_row(8'h41, 1'b0, 1'b1, 1'b0, 0, 0);
    directed_rows[4] = mk_row(8'h42, 1'b0, 1'b1, 1'b1, 1, 0);
    for (int i = 5; i < 13; i++) begin
      directed_rows[i] = mk_row(8'hFF, 1'b0, 1'b0, 1'b0, 0, 0);
    end
    directed_rows[13] = mk_row(8'hFF, 1'b1, 1'b0, 1'b0, 0, 0);
    directed_rows[14] = mk_row(8'h00, 1'b0, 1'b1, 1'b0, 0, 0);
    directed_rows[15] = mk_row(8'h00, 1'b0, 1'b1, 1'b1, 3, 0);
    for (int i = 16; i < 23; i++) begin
      directed_rows[i] = mk_row(8'h00, 1'b0, 1'b0, 1'b0, 0, 0);
    end
    directed_rows[23] = mk_row(8'h00, 1'b1, 1'b0, 1'b0, 0, 0);

    // single byte, two-byte with ignored tail, clamped length, identical slots
    set_b.pattern[0] = 64'h0000_0000_0000_00FF;
    set_b.pattern[1] = 64'hFFFF_FFFF_FFFF_4241;
    set_b.pattern[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    set_b.pattern[3] = 64'h0000_0000_0000_00FF;
    set_b.length[0]  = 4'd1;
    set_b.length[1]  = 4'd2;
    set_b.length[2]  = 4'd15;
    set_b.length[3]  = 4'd1;
    // zero runs against zero history, unused slot
    set_c.pattern[0] = 64'h0000_0000_0000_0000;
    set_c.pattern[1] = 64'h5A5A_5A5A_5A5A_5A5A;
    set_c.pattern[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    set_c.pattern[3] = 64'h0000_0000_0000_0000;
    set_c.length[0]  = 4'd8;
    set_c.length[1]  = 4'd0;
    set_c.length[2]  = 4'd8;
    set_c.length[3]  = 4'd2;

    for (int s = 0; s < SLOTS; s++) begin
      slot_pattern[s] = '0;
      slot_length[s]  = '0;
    end
    clear_stream();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == SET_B_FIRST) begin
        wait_drained();
        load_patterns(set_b);
      end
      if (i == SET_C_FIRST) begin
        wait_drained();
        load_patterns(set_c);
      end
      row = directed_rows[i];
      it.data_byte   = row.data_byte;
      it.end_of_file = row.end_of_file;
      send_item(it, !row.typed);
      if (row.typed && row.has_hit) begin
        pending_matches = {pending_matches, row.hit};
      end
    end

    wait_drained();
    load_patterns(random_set());
    run_random(ITEMS_PER_PHASE);

    wait_drained();
    tx_idle_pct = 78;
    rx_idle_pct <= 32;
    load_patterns(random_set());
    run_random(ITEMS_PER_PHASE);

    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    load_patterns(random_set());
    hold_req <= 1'b1;
    run_random(ITEMS_PER_PHASE);

    wait_drained();
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
